/* rtl/bfha_pkg.sv */
// Shared types and constants for the best-fit heap allocator.
package bfha_pkg;

  localparam int unsigned HeapBytesDef = 65536;
  localparam int unsigned GranBytes    = 8;
  localparam int unsigned HeadBytes    = 4;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_EMPTY   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic load;        // capture the input word
    logic empty;       // reset heap registers
    logic walk_start;  // clear walk pointer and trackers
    logic walk_step;   // read header at pointer
    logic walk_eval;   // evaluate header read last cycle
    logic rel_start;   // clear largest-free before release walk
    logic alloc_fit;   // commit best-fit split
    logic alloc_fit2;  // second header write of split
    logic alloc_tail;  // commit tail carve
    logic rel_tail;    // return tail free block to pool
    logic fail;        // flag allocation failure
    logic out_load;    // present result
  } cmd_t;

  typedef struct packed {
    logic       op_alloc;
    logic       op_release;
    logic       op_empty;
    logic       too_big;     // fits neither region
    logic       use_fit;     // fits largest free block
    logic       rel_skip;    // nothing allocated
    logic       walk_done;
    logic       best_ok;
    logic       split;       // remainder left after split
    logic       tail_free;   // last block free after release
  } sts_t;

endpackage

/* rtl/bfha_ctrl.sv */
// Controller state machine for the heap allocator.
module bfha_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  bfha_pkg::sts_t   sts_i,
  output bfha_pkg::cmd_t   cmd_o
);
  import bfha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WSTEP, S_WEVAL, S_FIT1, S_FIT2, S_RTAIL,
    S_RWSTEP, S_RWEVAL, S_OUT
  } state_e;

  typedef enum logic [1:0] { W_ALLOC, W_REL, W_RESCAN } walk_e;

  state_e state_q;
  walk_e  walk_q;
  logic   out_valid_q;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:   cmd_o.load = in_valid_i && !in_stall_o;
      S_DECODE: begin
        if (sts_i.op_empty) begin
          cmd_o.empty = 1'b1;
        end else if (sts_i.op_alloc) begin
          if (sts_i.too_big) begin
            cmd_o.fail = 1'b1;
          end else if (sts_i.use_fit) begin
            cmd_o.walk_start = 1'b1;
          end else begin
            cmd_o.alloc_tail = 1'b1;
          end
        end else if (sts_i.op_release && !sts_i.rel_skip) begin
          cmd_o.walk_start = 1'b1;
          cmd_o.rel_start  = 1'b1;
        end
      end
      S_WSTEP, S_RWSTEP: cmd_o.walk_step = 1'b1;
      S_WEVAL, S_RWEVAL: cmd_o.walk_eval = 1'b1;
      S_FIT1:   begin
        if (sts_i.best_ok) cmd_o.alloc_fit = 1'b1;
        else cmd_o.fail = 1'b1;
      end
      S_FIT2:   cmd_o.alloc_fit2 = 1'b1;
      S_RTAIL:  begin
        if (sts_i.tail_free) begin
          cmd_o.rel_tail   = 1'b1;
          cmd_o.walk_start = 1'b1;
        end
      end
      S_OUT:    cmd_o.out_load = !(out_valid_q && out_stall_i);
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      walk_q      <= W_ALLOC;
      out_valid_q <= 1'b0;
    end else begin
      // load a new result word or drop the one just taken
      if (cmd_o.out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE:   if (cmd_o.load) state_q <= S_DECODE;
        S_DECODE: begin
          if (cmd_o.walk_start) begin
            walk_q  <= sts_i.op_alloc ? W_ALLOC : W_REL;
            state_q <= S_WSTEP;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_WSTEP, S_RWSTEP: state_q <= (walk_q == W_REL) ? S_RWEVAL : S_WEVAL;
        S_WEVAL, S_RWEVAL: begin
          if (sts_i.walk_done) begin
            unique case (walk_q)
              W_ALLOC:  state_q <= S_FIT1;
              W_REL:    state_q <= S_RTAIL;
              default:  state_q <= S_OUT;
            endcase
          end else begin
            state_q <= (walk_q == W_REL) ? S_RWSTEP : S_WSTEP;
          end
        end
        S_FIT1:   state_q <= sts_i.best_ok ? S_FIT2 : S_OUT;
        S_FIT2:   state_q <= S_OUT;
        S_RTAIL:  begin
          if (sts_i.tail_free) begin
            walk_q  <= W_RESCAN;
            state_q <= S_WSTEP;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT:    begin
          if (cmd_o.out_load) state_q <= S_IDLE;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/bfha_dp.sv */
// Datapath: header memory, walk pointer, best-fit and merge trackers.
module bfha_dp #(
  parameter int unsigned HeapBytes = bfha_pkg::HeapBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfha_pkg::cmd_t             cmd_i,
  output bfha_pkg::sts_t             sts_o,
  input  logic [1:0]                 operation_i,
  input  logic [15:0]                request_bytes_i,
  input  logic [15:0]                release_offset_i,
  output logic [15:0]                block_offset_o,
  output logic                       alloc_failed_o,
  output logic [16:0]                largest_free_bytes_o,
  output logic [16:0]                unused_bytes_o
);
  import bfha_pkg::*;

  localparam int unsigned NGran = HeapBytes / GranBytes;
  localparam int unsigned AW    = $clog2(NGran);   // header index width
  localparam int unsigned GW    = AW + 1;          // granule count width
  localparam int unsigned HW    = GW + 1;          // header: size, in-use

  logic [HW-1:0] mem_q [NGran];
  logic [HW-1:0] rd_q;

  logic [1:0]  op_q;
  logic [15:0] rel_q;
  logic [GW-1:0] g_q;
  logic [GW-1:0] lf_start_q, lf_size_q, un_start_q, un_size_q;
  logic [GW-1:0] ptr_q, n_q;
  logic          best_ok_q, prev_ok_q, prev_free_q, res_fail_q;
  logic [GW-1:0] best_q, best_size_q, next_q, next_size_q, prev_q, prev_size_q;
  logic [15:0]   res_off_q;
  logic [15:0]   out_off_q;
  logic          out_fail_q;
  logic [16:0]   out_lf_q, out_un_q;
  logic          rescan_q;

  // Granules for request: ceil((req+4)/8)
  logic [13:0] g_calc;
  assign g_calc = 14'((18'(request_bytes_i) + 18'(HeadBytes + GranBytes - 1)) >> 3);

  // Memory port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [HW-1:0] wr_data;
  logic          rd_ok;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.walk_step) rd_q <= mem_q[ptr_q[AW-1:0]];
  end
  assign rd_ok = (ptr_q < GW'(NGran));

  // Walk evaluation
  logic [HW-1:0] h;
  logic [GW-1:0] sz, msize, mptr, nptr;
  logic          used, hit, merge, wdone;
  logic [GW+3:0] lo_b, hi_b;

  always_comb begin
    h     = rd_ok ? rd_q : '0;
    sz    = h[HW-1:1];
    used  = h[0];
    lo_b  = {ptr_q, 3'b000} + (GW+4)'(HeadBytes);
    hi_b  = (GW+4)'({(ptr_q + sz), 3'b000});
    hit   = used && ((GW+4)'(rel_q) >= lo_b) && ((GW+4)'(rel_q) < hi_b);
    merge = prev_ok_q && prev_free_q && (!used || hit);
    mptr  = merge ? prev_q : ptr_q;
    msize = merge ? sz + prev_size_q : sz;
    nptr  = mptr + msize;
    wdone = (sz == '0) || (nptr >= un_start_q) || (n_q + 1'b1 >= GW'(NGran));
  end

  logic rel_walk;
  assign rel_walk = (op_q == OP_RELEASE) && !rescan_q;

  // Header writes
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd_i.walk_eval && rel_walk && sz != '0 && (hit || merge) && mptr < GW'(NGran)) begin
      wr_en   = 1'b1;
      wr_addr = mptr[AW-1:0];
      wr_data = {msize, 1'b0};
    end else if (cmd_i.alloc_fit && best_size_q > g_q && (best_q + g_q) < GW'(NGran)) begin
      wr_en   = 1'b1;
      wr_addr = AW'(best_q + g_q);
      wr_data = {GW'(best_size_q - g_q), 1'b0};
    end else if (cmd_i.alloc_fit2) begin
      wr_en   = 1'b1;
      wr_addr = best_q[AW-1:0];
      wr_data = {g_q, 1'b1};
    end else if (cmd_i.alloc_tail && un_start_q < GW'(NGran)) begin
      wr_en   = 1'b1;
      wr_addr = un_start_q[AW-1:0];
      wr_data = {g_q, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lf_start_q <= '0;
      lf_size_q  <= '0;
      un_start_q <= '0;
      un_size_q  <= GW'(NGran);
      rescan_q   <= 1'b0;
      best_ok_q  <= 1'b0;
      prev_ok_q  <= 1'b0;
      prev_free_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        op_q       <= operation_i;
        rel_q      <= release_offset_i;
        g_q        <= (g_calc > 14'((1 << GW) - 1)) ? '1 : GW'(g_calc);
        res_off_q  <= '0;
        res_fail_q <= 1'b0;
        rescan_q   <= 1'b0;
      end
      if (cmd_i.empty) begin
        lf_start_q <= '0;
        lf_size_q  <= '0;
        un_start_q <= '0;
        un_size_q  <= GW'(NGran);
      end
      if (cmd_i.fail) res_fail_q <= 1'b1;
      if (cmd_i.walk_start) begin
        ptr_q       <= '0;
        n_q         <= '0;
        best_ok_q   <= 1'b0;
        best_q      <= '0;
        best_size_q <= '0;
        next_q      <= '0;
        next_size_q <= '0;
        prev_ok_q   <= 1'b0;
        prev_free_q <= 1'b0;
        if (cmd_i.rel_start) begin
          lf_start_q <= '0;
          lf_size_q  <= '0;
        end
      end
      if (cmd_i.rel_tail) begin
        un_start_q <= prev_q;
        un_size_q  <= un_size_q + prev_size_q;
        rescan_q   <= 1'b1;
        lf_start_q <= '0;
        lf_size_q  <= '0;
      end
      if (cmd_i.walk_eval) begin
        if (rel_walk) begin
          if (sz != '0) begin
            if ((!used || hit) && msize > lf_size_q) begin
              lf_start_q <= mptr;
              lf_size_q  <= msize;
            end
            prev_ok_q   <= 1'b1;
            prev_free_q <= !used || hit;
            prev_q      <= mptr;
            prev_size_q <= msize;
          end
          ptr_q <= nptr;
        end else begin
          if (sz != '0 && !used) begin
            if (rescan_q) begin
              // an empty chain leaves nothing below the pool to scan
              if (sz > lf_size_q && ptr_q < un_start_q) begin
                lf_start_q <= ptr_q;
                lf_size_q  <= sz;
              end
            end else begin
              if (sz >= g_q && (!best_ok_q || sz < best_size_q)) begin
                best_ok_q   <= 1'b1;
                best_q      <= ptr_q;
                best_size_q <= sz;
              end
              if (ptr_q != lf_start_q && sz > next_size_q) begin
                next_q      <= ptr_q;
                next_size_q <= sz;
              end
            end
          end
          ptr_q <= ptr_q + sz;
        end
        n_q <= n_q + 1'b1;
      end
      if (cmd_i.alloc_fit) begin
        if (best_q == lf_start_q) begin
          lf_start_q <= next_q;
          lf_size_q  <= next_size_q;
        end
        res_off_q <= 16'({best_q, 3'b000} + (GW+3)'(HeadBytes));
      end
      if (cmd_i.alloc_tail) begin
        res_off_q  <= 16'({un_start_q, 3'b000} + (GW+3)'(HeadBytes));
        un_start_q <= un_start_q + g_q;
        un_size_q  <= un_size_q - g_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_off_q  <= res_off_q;
      out_fail_q <= res_fail_q;
      out_lf_q   <= 17'({lf_size_q, 3'b000});
      out_un_q   <= 17'({un_size_q, 3'b000});
    end
  end

  assign block_offset_o       = out_off_q;
  assign alloc_failed_o       = out_fail_q;
  assign largest_free_bytes_o = out_lf_q;
  assign unused_bytes_o       = out_un_q;

  always_comb begin
    sts_o            = '0;
    sts_o.op_alloc   = (op_q == OP_ALLOC);
    sts_o.op_release = (op_q == OP_RELEASE);
    sts_o.op_empty   = (op_q == OP_EMPTY);
    sts_o.too_big    = (g_q > lf_size_q) && (g_q > un_size_q);
    sts_o.use_fit    = (g_q <= lf_size_q);
    sts_o.rel_skip   = (un_start_q == '0);
    sts_o.walk_done  = wdone;
    sts_o.best_ok    = best_ok_q;
    sts_o.split      = best_size_q > g_q;
    sts_o.tail_free  = prev_ok_q && prev_free_q;
  end

endmodule

/* rtl/best_fit_heap_allocator.sv */
// Each header walked takes a read step and an evaluate step. An allocation
// fitting the largest free block, or a release into a non-empty heap, walks
// up to HeapBytes/8 headers, twice when a release returns a tail block. One
// word is taken at a time, limited by the walk. Reset clears the region
// registers at once; header memory has no reset and needs no clearing pass.
// Top level of the best-fit heap allocator.
module best_fit_heap_allocator #(
  parameter int unsigned HeapBytes = bfha_pkg::HeapBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] release_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] block_offset_o,
  output logic        alloc_failed_o,
  output logic [16:0] largest_free_bytes_o,
  output logic [16:0] unused_bytes_o
);
  import bfha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  bfha_dp #(.HeapBytes(HeapBytes)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .operation_i, .request_bytes_i, .release_offset_i,
    .block_offset_o, .alloc_failed_o, .largest_free_bytes_o, .unused_bytes_o
  );

endmodule

/* rtl/bfha_chk.sv */
// Port checker for the heap allocator, bound to the top level.
module bfha_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] block_offset_o,
  input logic        alloc_failed_o,
  input logic [16:0] largest_free_bytes_o,
  input logic [16:0] unused_bytes_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(block_offset_o))
    else $error("result word changed while stalled");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alloc_failed_o |-> block_offset_o == 16'd0)
    else $error("failed allocation gave an offset");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while busy");
  a_gran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> largest_free_bytes_o[2:0] == 3'd0 && unused_bytes_o[2:0] == 3'd0)
    else $error("byte counts not whole granules");
endmodule

bind best_fit_heap_allocator bfha_chk u_chk (.*);
